[hw/rtl/selsort_pkg.sv]
package selsort_pkg;

  localparam int unsigned DATA_W = 32;

  // sequencer states
  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // tag that travels with each store read
  typedef struct packed {
    logic vld;
    logic first;
  } scan_t;

endpackage

[hw/rtl/selsort_store.sv]
module selsort_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic [selsort_pkg::DATA_W-1:0]     wdata,
  input  logic                               re,
  input  logic [AW-1:0]                      raddr,
  output logic [selsort_pkg::DATA_W-1:0]     rd_data
);

  logic [selsort_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

[hw/rtl/selsort_min.sv]
module selsort_min #(
  parameter int unsigned AW = 6
) (
  input  logic                               clk,
  input  selsort_pkg::scan_t                 rd,
  input  logic [AW-1:0]                      rd_idx,
  input  logic [selsort_pkg::DATA_W-1:0]     rd_data,
  output logic [selsort_pkg::DATA_W-1:0]     best_val,
  output logic [AW-1:0]                      best_idx,
  output logic [selsort_pkg::DATA_W-1:0]     pos_val
);

  logic lt;

  // strict signed less-than keeps the first minimum found
  assign lt = $signed(rd_data) < $signed(best_val);

  always_ff @(posedge clk) begin
    if (rd.vld) begin
      if (rd.first) begin
        best_val <= rd_data;
        best_idx <= rd_idx;
        pos_val  <= rd_data;
      end else if (lt) begin
        best_val <= rd_data;
        best_idx <= rd_idx;
      end
    end
  end

endmodule

[hw/rtl/selection_sorter_core.sv]
// channel | handshake            | payload
// in      | in_valid / in_ready  | value, is_last
// out     | out_valid / out_ready| sorted_value, last_out, overflow
//
// loading takes one cycle per item; nothing comes out until the item marked last
// sorting a batch: for each position in turn, the store is read from that position to
// the last stored value through its single read port into the one comparator; then the
// minimum is emitted and the position's old value moves to where it was found
// each sorted value leaves through an output register as soon as its position is done
// reset clears the count, the drop flag and the output valid; the store is not cleared
// in_ready is low from the last item of a batch until its final result is registered
module selection_sorter_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sorted_value,
  output logic               last_out,
  output logic               overflow
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  selsort_pkg::state_t state;
  logic [CW-1:0]       count;
  logic                dropped;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       issue_idx;
  selsort_pkg::scan_t  rd;
  logic [AW-1:0]       rd_idx;

  logic                             in_acc;
  logic                             full;
  logic                             issue;
  logic                             emit_go;
  logic                             last_pos;
  logic                             st_we;
  logic [AW-1:0]                    st_waddr;
  logic [selsort_pkg::DATA_W-1:0]   st_wdata;
  logic [selsort_pkg::DATA_W-1:0]   rd_data;
  logic [selsort_pkg::DATA_W-1:0]   best_val;
  logic [AW-1:0]                    best_idx;
  logic [selsort_pkg::DATA_W-1:0]   pos_val;

  assign in_ready = (state == selsort_pkg::S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count == CW'(CAPACITY));
  assign issue    = (state == selsort_pkg::S_SCAN) && (issue_idx != count);
  assign emit_go  = (state == selsort_pkg::S_EMIT) && (!out_valid || out_ready);
  assign last_pos = ((pos + CW'(1)) == count);

  // emit writes the old value of this position where the minimum was found
  always_comb begin
    st_we    = (in_acc && !full) || emit_go;
    st_waddr = emit_go ? best_idx : count[AW-1:0];
    st_wdata = emit_go ? pos_val : value;
  end

  selsort_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .re      (issue),
    .raddr   (issue_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  selsort_min #(
    .AW (AW)
  ) u_min (
    .clk      (clk),
    .rd       (rd),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .best_val (best_val),
    .best_idx (best_idx),
    .pos_val  (pos_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= selsort_pkg::S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      pos       <= '0;
      issue_idx <= '0;
      rd        <= '0;
      out_valid <= 1'b0;
    end else begin
      rd.vld   <= issue;
      rd.first <= (issue_idx == pos);
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        selsort_pkg::S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (is_last) begin
              state     <= selsort_pkg::S_SCAN;
              pos       <= '0;
              issue_idx <= '0;
            end
          end
        end
        selsort_pkg::S_SCAN: begin
          if (issue) begin
            issue_idx <= issue_idx + CW'(1);
          end else if (!rd.vld) begin
            state <= selsort_pkg::S_EMIT;
          end
        end
        selsort_pkg::S_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            if (last_pos) begin
              state   <= selsort_pkg::S_LOAD;
              count   <= '0;
              dropped <= 1'b0;
            end else begin
              pos       <= pos + CW'(1);
              issue_idx <= pos + CW'(1);
              state     <= selsort_pkg::S_SCAN;
            end
          end
        end
        default: begin
          state <= selsort_pkg::S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[AW-1:0];
    if (emit_go) begin
      sorted_value <= best_val;
      last_out     <= last_pos;
      overflow     <= dropped;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == selsort_pkg::S_SCAN) |-> (issue_idx <= count) && (pos < count))
    else $error("scan index outside the stored set");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && is_last) |=>
      (state == selsort_pkg::S_SCAN) && (pos == '0) && (count != '0))
    else $error("last item did not start a sort");

endmodule
